// ----- src/longest_window_exactly_k_distinct_top_assert.svh -----
// Assertion macros for the longest window block.
`ifndef LONGEST_WINDOW_EXACTLY_K_DISTINCT_TOP_ASSERT_SVH
`define LONGEST_WINDOW_EXACTLY_K_DISTINCT_TOP_ASSERT_SVH

// same-cycle implication
`define LWKD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lwkd: assertion failed");

// next-cycle implication
`define LWKD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lwkd: assertion failed");

`endif

// ----- src/lwkd_pkg.sv -----
`timescale 1ns / 1ps

package lwkd_pkg;

  localparam int RING_DEPTH = 4096;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int WL_W       = $clog2(RING_DEPTH + 1);
  localparam int CNT_W      = $clog2(RING_DEPTH + 2);
  localparam int SYM_W      = 8;
  localparam int NUM_SYM    = 256;
  localparam int K_W        = 9;
  localparam int LEN_W      = 14;
  localparam int CMP_W      = (WL_W + 1 > LEN_W) ? WL_W + 1 : LEN_W;

  localparam logic [K_W-1:0] K_RESET = K_W'(2);

  typedef struct packed {
    logic             clr;
    logic             rd_en;
    logic [SYM_W-1:0] rd_addr;
    logic             wr_en;
    logic [SYM_W-1:0] wr_addr;
    logic [CNT_W-1:0] wr_data;
  } cnt_req_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ADD    = 6'b000010,
    S_EV_CNT = 6'b000100,
    S_UPD    = 6'b001000,
    S_COMMIT = 6'b010000,
    S_FIN    = 6'b100000
  } state_e;

  function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] idx);
    ring_next = (idx == RING_AW'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

endpackage

// ----- src/lwkd_ram.sv -----
`timescale 1ns / 1ps

module lwkd_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/lwkd_cnt_tab.sv -----
`timescale 1ns / 1ps

module lwkd_cnt_tab import lwkd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cnt_req_t         req_i,
  output logic [CNT_W-1:0] rdata_o
);

  logic [CNT_W-1:0] mem [NUM_SYM];
  logic [CNT_W-1:0] rdata_q;
  logic [NUM_SYM-1:0] vld_q;
  logic             rvld_q;

  // an entry not written since the last clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        rvld_q <= vld_q[req_i.rd_addr];
      end
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ----- src/longest_window_exactly_k_distinct_top.sv -----
`timescale 1ns / 1ps
// Channel | Direction | Handshake                 | Payload
// in      | in        | in_valid_i / in_ready_o   | symbol_i, has_symbol_i, last_i
// out     | out       | out_valid_o / out_ready_i | longest_length_o, overflow_o
// cfg     | in        | cfg_we_i                  | cfg_wdata_i
//
// An item with a symbol does a count table read and write-back; each evicted byte adds a ring
// read, a count read and a count write-back, and a new byte dropped after evictions adds a
// commit step. A last item adds a final step that hands out the result and clears the window.
// Reset needs no clearing pass: the count table has a valid bit per entry.
// A new item is taken while a result waits; a last item then holds until the result leaves.

module longest_window_exactly_k_distinct_top import lwkd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [SYM_W-1:0]        symbol_i,
  input  logic                    has_symbol_i,
  input  logic                    last_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [LEN_W-1:0] longest_length_o,
  output logic                    overflow_o,
  input  logic                    cfg_we_i,
  input  logic [K_W-1:0]          cfg_wdata_i
);

  state_e state_q, state_d;

  logic [K_W-1:0]          k_q;
  logic [SYM_W-1:0]        sym_q, sym_d;
  logic [SYM_W-1:0]        evb_q, evb_d;
  logic                    last_q, last_d;
  logic [CNT_W-1:0]        cntb_q, cntb_d;
  logic [K_W-1:0]          dist_q, dist_d;
  logic [RING_AW-1:0]      head_q, head_d;
  logic [RING_AW-1:0]      tail_q, tail_d;
  logic [WL_W-1:0]         wl_q, wl_d;
  logic signed [LEN_W-1:0] best_q, best_d;
  logic                    ovf_q, ovf_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [LEN_W-1:0] out_len_q, out_len_d;
  logic                    out_ovf_q, out_ovf_d;

  cnt_req_t           cnt_req;
  logic [CNT_W-1:0]   cnt_rdata;
  logic               ring_we, ring_re;
  logic [RING_AW-1:0] ring_raddr;
  logic [SYM_W-1:0]   ring_rdata;

  logic [CNT_W-1:0]   ce_dec;
  logic [K_W-1:0]     cur_dist, dist_fin;
  logic [WL_W-1:0]    cur_wl, wl_fin;
  logic [RING_AW-1:0] cur_tail;
  logic [CNT_W-1:0]   cur_cntb, cntb_fin;
  logic               ev_k, ev_full, evict, undo, accept;
  logic signed [CMP_W-1:0] wl_ext, best_ext;

  lwkd_cnt_tab u_cnt_tab (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cnt_req),
    .rdata_o(cnt_rdata)
  );

  lwkd_ram #(
    .DW   (SYM_W),
    .DEPTH(RING_DEPTH),
    .AW   (RING_AW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(head_q),
    .wdata_i(sym_q),
    .re_i   (ring_re),
    .raddr_i(ring_raddr),
    .rdata_o(ring_rdata)
  );

  assign accept = in_valid_i && in_ready_o;
  assign ce_dec = (cnt_rdata != '0) ? cnt_rdata - CNT_W'(1) : cnt_rdata;

  // window view after this cycle's count update
  always_comb begin
    cur_dist = dist_q;
    cur_wl   = wl_q;
    cur_tail = tail_q;
    cur_cntb = cntb_q;
    priority if (state_q == S_ADD) begin
      cur_cntb = cnt_rdata + CNT_W'(1);
      cur_dist = dist_q + K_W'(cnt_rdata == '0);
    end else if (state_q == S_UPD) begin
      cur_dist = dist_q - K_W'((cnt_rdata == CNT_W'(1)) && (dist_q != '0));
      cur_wl   = wl_q - WL_W'(1);
      cur_tail = ring_next(tail_q);
      cur_cntb = (evb_q == sym_q) ? ce_dec : cntb_q;
    end else begin
      cur_cntb = cntb_q;
    end
  end

  always_comb begin
    ev_k     = (cur_dist > k_q) && (cur_wl != '0);
    ev_full  = (cur_dist <= k_q) && (cur_wl >= WL_W'(RING_DEPTH));
    evict    = ev_k || ev_full;
    undo     = cur_dist > k_q;
    cntb_fin = undo ? cur_cntb - CNT_W'(1) : cur_cntb;
    dist_fin = undo ? cur_dist - K_W'(cntb_fin == '0) : cur_dist;
    wl_fin   = undo ? cur_wl : cur_wl + WL_W'(1);
    wl_ext   = $signed({{(CMP_W - WL_W){1'b0}}, wl_fin});
    best_ext = CMP_W'(best_q);
  end

  always_comb begin
    state_d     = state_q;
    sym_d       = sym_q;
    evb_d       = evb_q;
    last_d      = last_q;
    cntb_d      = cntb_q;
    dist_d      = dist_q;
    head_d      = head_q;
    tail_d      = tail_q;
    wl_d        = wl_q;
    best_d      = best_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_len_d   = out_len_q;
    out_ovf_d   = out_ovf_q;
    cnt_req     = '0;
    ring_we     = 1'b0;
    ring_re     = 1'b0;
    ring_raddr  = cur_tail;
    in_ready_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          sym_d  = symbol_i;
          last_d = last_i;
          if (has_symbol_i) begin
            cnt_req.rd_en   = 1'b1;
            cnt_req.rd_addr = symbol_i;
            state_d         = S_ADD;
          end else if (last_i) begin
            state_d = S_FIN;
          end
        end
      end
      S_EV_CNT: begin
        cnt_req.rd_en   = 1'b1;
        cnt_req.rd_addr = ring_rdata;
        evb_d           = ring_rdata;
        state_d         = S_UPD;
      end
      S_ADD, S_UPD, S_COMMIT: begin
        if (state_q == S_ADD) begin
          cnt_req.wr_en   = 1'b1;
          cnt_req.wr_addr = sym_q;
          cnt_req.wr_data = evict ? cur_cntb : cntb_fin;
        end else if (state_q == S_UPD) begin
          cnt_req.wr_en   = 1'b1;
          cnt_req.wr_addr = evb_q;
          cnt_req.wr_data = ce_dec;
        end else begin
          cnt_req.wr_en   = undo;
          cnt_req.wr_addr = sym_q;
          cnt_req.wr_data = cntb_fin;
        end
        if (evict) begin
          ring_re = 1'b1;
          dist_d  = cur_dist;
          wl_d    = cur_wl;
          tail_d  = cur_tail;
          cntb_d  = cur_cntb;
          if (ev_full) begin
            ovf_d = 1'b1;
          end
          state_d = S_EV_CNT;
        end else if ((state_q == S_UPD) && undo) begin
          // count port busy with the evicted byte: drop the new byte next cycle
          dist_d  = cur_dist;
          wl_d    = cur_wl;
          tail_d  = cur_tail;
          cntb_d  = cur_cntb;
          state_d = S_COMMIT;
        end else begin
          ring_we = !undo;
          head_d  = undo ? head_q : ring_next(head_q);
          dist_d  = dist_fin;
          wl_d    = wl_fin;
          tail_d  = cur_tail;
          cntb_d  = cntb_fin;
          if ((dist_fin == k_q) && (wl_ext > best_ext)) begin
            best_d = LEN_W'(wl_fin);
          end
          state_d = last_q ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_len_d   = best_q;
          out_ovf_d   = ovf_q;
          cnt_req.clr = 1'b1;
          dist_d      = '0;
          head_d      = '0;
          tail_d      = '0;
          wl_d        = '0;
          best_d      = -LEN_W'(1);
          ovf_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= K_RESET;
      last_q      <= 1'b0;
      dist_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      wl_q        <= '0;
      best_q      <= -LEN_W'(1);
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      dist_q      <= dist_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      wl_q        <= wl_d;
      best_q      <= best_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        k_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q     <= sym_d;
    evb_q     <= evb_d;
    cntb_q    <= cntb_d;
    out_len_q <= out_len_d;
    out_ovf_q <= out_ovf_d;
  end

  assign out_valid_o      = out_valid_q;
  assign longest_length_o = out_len_q;
  assign overflow_o       = out_ovf_q;

`include "longest_window_exactly_k_distinct_top_assert.svh"

  `LWKD_ASSERT_IMP(a_wl_bound, 1'b1, wl_q <= WL_W'(RING_DEPTH))
  `LWKD_ASSERT_IMP(a_evict_nonempty, state_q == S_EV_CNT, wl_q != '0)
  `LWKD_ASSERT_NXT(a_fin_clears, (state_q == S_FIN) && (!out_valid_q || out_ready_i),
                   out_valid_o && (best_q == -LEN_W'(1)) && (wl_q == '0))

endmodule

// ----- verif/window_length_scoreboard.sv -----
`timescale 1ns / 1ps

module window_length_scoreboard import lwkd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [SYM_W-1:0]        symbol_i,
  input  logic                    has_symbol_i,
  input  logic                    last_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [LEN_W-1:0] longest_length_i,
  input  logic                    overflow_i,
  input  logic                    cfg_we_i,
  input  logic [K_W-1:0]          cfg_wdata_i,
  output int                      mismatch_count_o,
  output int                      results_owed_o
);

  typedef struct packed {
    logic signed [LEN_W-1:0] length;
    logic                    overflow;
  } window_result_t;

  window_result_t          expected_lengths[$];
  logic [K_W-1:0]          target;
  logic [CNT_W-1:0]        sym_count [NUM_SYM];
  logic [K_W-1:0]          distinct;
  logic [SYM_W-1:0]        ring [RING_DEPTH];
  logic [RING_AW-1:0]      head;
  logic [RING_AW-1:0]      tail;
  logic [WL_W-1:0]         win_len;
  logic signed [LEN_W-1:0] best;
  logic                    ovf;

  task automatic clear_window();
    for (int i = 0; i < NUM_SYM; i++) sym_count[i] = '0;
    distinct = '0;
    head     = '0;
    tail     = '0;
    win_len  = '0;
    best     = -1;
    ovf      = 1'b0;
  endtask

  task automatic drop_oldest();
    logic [SYM_W-1:0] b;
    if (win_len == 0) return;
    b = ring[tail];
    if (sym_count[b] != 0) begin
      sym_count[b] = sym_count[b] - 1'b1;
      if (sym_count[b] == 0 && distinct != 0) distinct = distinct - 1'b1;
    end
    tail    = (tail == RING_AW'(RING_DEPTH - 1)) ? '0 : tail + 1'b1;
    win_len = win_len - 1'b1;
  endtask

  task automatic absorb_symbol(input logic [SYM_W-1:0] b);
    sym_count[b] = sym_count[b] + 1'b1;
    if (sym_count[b] == 1) distinct = distinct + 1'b1;
    while (distinct > target && win_len != 0) drop_oldest();
    if (distinct > target) begin
      // zero target: new byte is not kept
      sym_count[b] = sym_count[b] - 1'b1;
      if (sym_count[b] == 0) distinct = distinct - 1'b1;
    end else begin
      if (win_len >= RING_DEPTH) begin
        drop_oldest();
        ovf = 1'b1;
      end
      ring[head] = b;
      head       = (head == RING_AW'(RING_DEPTH - 1)) ? '0 : head + 1'b1;
      win_len    = win_len + 1'b1;
    end
    if (distinct == target && $signed({1'b0, win_len}) > best)
      best = LEN_W'(win_len);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    window_result_t want;
    if (!rst_ni) begin
      clear_window();
      target = K_RESET;
      expected_lengths.delete();
      mismatch_count_o = 0;
      results_owed_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_lengths.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual length %0d overflow %0b",
                   $time, longest_length_i, overflow_i);
          mismatch_count_o++;
        end else begin
          want = expected_lengths.pop_front();
          if (longest_length_i !== want.length) begin
            $display("%0t: longest_length expected %0d actual %0d",
                     $time, want.length, longest_length_i);
            mismatch_count_o++;
          end
          if (overflow_i !== want.overflow) begin
            $display("%0t: overflow expected %0b actual %0b",
                     $time, want.overflow, overflow_i);
            mismatch_count_o++;
          end
        end
      end
      if (cfg_we_i) target = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        if (has_symbol_i) absorb_symbol(symbol_i);
        if (last_i) begin
          want.length   = best;
          want.overflow = ovf;
          expected_lengths.push_back(want);
          clear_window();
        end
      end
      results_owed_o = expected_lengths.size();
    end
  end

endmodule

// ----- verif/tb_longest_window_exactly_k_distinct_top.sv -----
`timescale 1ns / 1ps

module tb_longest_window_exactly_k_distinct_top import lwkd_pkg::*;;

  localparam int QUIET_LIMIT = 40000;
  localparam int ITEM_TARGET = 1520;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid;
  logic                    in_ready;
  logic [SYM_W-1:0]        in_symbol;
  logic                    in_has;
  logic                    in_last;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [LEN_W-1:0] longest_length;
  logic                    overflow;
  logic                    cfg_we;
  logic [K_W-1:0]          cfg_wdata;
  logic                    in_fire;
  int                      mismatch_count;
  int                      results_owed;
  int                      items_sent;
  int                      burst_left;
  int                      quiet_cycles;
  logic [SYM_W-1:0]        alpha [NUM_SYM];

  longest_window_exactly_k_distinct_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .symbol_i         (in_symbol),
    .has_symbol_i     (in_has),
    .last_i           (in_last),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .longest_length_o (longest_length),
    .overflow_o       (overflow),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata)
  );

  window_length_scoreboard u_scoreboard (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .symbol_i         (in_symbol),
    .has_symbol_i     (in_has),
    .last_i           (in_last),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .longest_length_i (longest_length),
    .overflow_i       (overflow),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatch_count),
    .results_owed_o   (results_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) in_fire <= in_valid && in_ready;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver stall pattern
  initial begin
    int  mode;
    int  span;
    int  hold;
    bit  lvl;
    out_ready = 1'b0;
    hold      = 0;
    lvl       = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(50, 300);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            if (hold == 0) begin
              lvl  = !lvl;
              hold = lvl ? $urandom_range(1, 4) : $urandom_range(1, 30);
            end
            hold--;
            out_ready <= lvl;
          end
        endcase
      end
    end
  end

  task automatic put_item(input logic [SYM_W-1:0] s, input logic h, input logic l);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_symbol <= s;
    in_has    <= h;
    in_last   <= l;
    do @(negedge clk_i); while (!in_fire);
    if (h || l) items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (results_owed != 0);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic apply_target(input int k);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= K_W'(k);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic shuffle_alphabet();
    int               j;
    logic [SYM_W-1:0] t;
    for (int i = NUM_SYM - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = alpha[i];
      alpha[i] = alpha[j];
      alpha[j] = t;
    end
  endtask

  task automatic send_string(input int k);
    int               kind;
    int               a;
    int               len;
    bit               sweep;
    bit               bare_end;
    logic [SYM_W-1:0] s;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      put_item(SYM_W'($urandom), 1'b0, 1'b1);
      return;
    end
    shuffle_alphabet();
    if (kind == 1) a = NUM_SYM;
    else if (k == 0) a = $urandom_range(1, 3);
    else if (k > NUM_SYM) a = $urandom_range(1, 12);
    else begin
      a = k + $urandom_range(0, 3) - 1;
      if (a < 1) a = 1;
      if (a > NUM_SYM) a = NUM_SYM;
    end
    if (a > 32 && kind != 1) begin
      len   = a + $urandom_range(0, 40);
      sweep = $urandom_range(0, 9) < 7;
    end else begin
      len   = $urandom_range(1, 40);
      sweep = (len >= a) && ($urandom_range(0, 2) == 0);
    end
    bare_end = $urandom_range(0, 9) == 0;
    for (int pos = 0; pos < len; pos++) begin
      if ($urandom_range(0, 24) == 0) put_item(SYM_W'($urandom), 1'b0, 1'b0);
      s = (sweep && pos < a) ? alpha[pos] : alpha[$urandom_range(0, a - 1)];
      put_item(s, 1'b1, (pos == len - 1) && !bare_end);
    end
    if (bare_end) put_item(SYM_W'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int k;
    int phase_start;
    for (int i = 0; i < NUM_SYM; i++) alpha[i] = SYM_W'(i);
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_symbol    = '0;
    in_has       = 1'b0;
    in_last      = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    items_sent   = 0;
    burst_left   = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset target of two: empty string, ignored item mid-string, single byte
    put_item(8'h00, 1'b0, 1'b1);
    put_item(8'h00, 1'b1, 1'b0);
    put_item(8'hFF, 1'b1, 1'b0);
    put_item(8'h00, 1'b1, 1'b0);
    put_item(8'h5A, 1'b0, 1'b0);
    put_item(8'h80, 1'b1, 1'b1);
    put_item(8'h7F, 1'b1, 1'b1);
    apply_target(0);
    put_item(8'h11, 1'b1, 1'b0);
    put_item(8'h22, 1'b1, 1'b1);
    put_item(8'hC3, 1'b0, 1'b1);
    apply_target(1);
    put_item(8'hFF, 1'b1, 1'b0);
    put_item(8'hFF, 1'b1, 1'b0);
    put_item(8'hFF, 1'b1, 1'b0);
    put_item(8'h01, 1'b1, 1'b1);
    apply_target(511);
    put_item(8'h00, 1'b1, 1'b0);
    put_item(8'hFF, 1'b1, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       k = 0;
        1:       k = 1;
        2:       k = 2;
        3:       k = $urandom_range(3, 8);
        4:       k = $urandom_range(0, 16);
        5:       k = $urandom_range(0, 511);
        6:       k = 256;
        7:       k = 255;
        8:       k = 511;
        default: k = $urandom_range(4, 40);
      endcase
      apply_target(k);
      phase_start = items_sent;
      while (items_sent - phase_start < 120 && items_sent < ITEM_TARGET) send_string(k);
    end

    // a third byte forcing a long run of evictions
    apply_target(2);
    shuffle_alphabet();
    for (int i = 0; i < 240; i++) put_item(alpha[$urandom_range(0, 1)], 1'b1, 1'b0);
    for (int i = 0; i < 40; i++) put_item(alpha[0], 1'b1, 1'b0);
    put_item(alpha[2], 1'b1, 1'b1);

    drain();
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
